[rtl/assert_macros.svh]
// Assertion macros used by the datapath of the recurrence core.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/lrmp_pkg.sv]
// Shared types and constants of the linear recurrence core.
// No dependencies; used by the datapath, the controller and the top level.
package lrmp_pkg;

    localparam int INDEX_BITS = 60;
    localparam int DATA_W     = 30;

    localparam logic [29:0] PRIME      = 30'd1000000007;
    localparam logic [31:0] PRIME_X2   = 32'd2000000014;
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = 5;

    localparam logic [1:0] ROW_VEC   = 2'd3;
    localparam logic [1:0] FIRST_IDX = 2'd0;
    localparam logic [1:0] LAST_IDX  = 2'd2;
    localparam logic [1:0] FIN_BASE  = 2'd3;

    localparam int          PIPE_STAGES = 6;
    localparam int          CNT_W       = 4;
    localparam logic [3:0]  INIT_LAST   = 4'd15;
    localparam logic [3:0]  DRAIN_LAST  = 4'd6;

    localparam int APB_AW = 5;

    localparam logic [29:0] RST_COEF_ONE   = 30'd2;
    localparam logic [29:0] RST_COEF_TWO   = 30'd3;
    localparam logic [29:0] RST_COEF_THREE = 30'd2;
    localparam logic [29:0] RST_FIRST      = 30'd2;
    localparam logic [29:0] RST_SECOND     = 30'd7;
    localparam logic [29:0] RST_THIRD      = 30'd22;

    typedef enum logic [2:0] {
        REG_COEF_ONE   = 3'd0,
        REG_COEF_TWO   = 3'd1,
        REG_COEF_THREE = 3'd2,
        REG_FIRST      = 3'd3,
        REG_SECOND     = 3'd4,
        REG_THIRD      = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_STEP,
        ST_READ,
        ST_CAPTURE
    } state_t;

    typedef struct packed {
        logic [29:0] coef_one;
        logic [29:0] coef_two;
        logic [29:0] coef_three;
        logic [29:0] first;
        logic [29:0] second;
        logic [29:0] third;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       init_wr;
        logic [1:0] init_row;
        logic [1:0] init_col;
        logic       issue;
        logic       vec_phase;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        logic       step;
        logic       capture;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_bit0;
        logic n_large;
        logic out_full;
    } status_t;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [RAM_AW-1:0] dest;
    } tag_t;

endpackage

[rtl/lrmp_ram.sv]
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module lrmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_a_addr];
        rd_b_reg <= mem_reg[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

[rtl/lrmp_datapath.sv]
// Datapath: operand RAM, pipelined Barrett modular multiplier, accumulator,
// index register and result register. Depends on lrmp_pkg, lrmp_ram and assert_macros.svh.
`include "assert_macros.svh"

module lrmp_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lrmp_pkg::cmd_t                     cmd,
    output lrmp_pkg::status_t                  status,
    input  lrmp_pkg::cfg_t                     cfg,
    input  logic [lrmp_pkg::INDEX_BITS-1:0]    s_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lrmp_pkg::DATA_W-1:0]        m_term_value
);

    localparam int IW = lrmp_pkg::INDEX_BITS;
    localparam int DW = lrmp_pkg::DATA_W;
    localparam int AW = lrmp_pkg::RAM_AW;
    localparam int PS = lrmp_pkg::PIPE_STAGES;

    function automatic logic [29:0] red30(input logic [29:0] x);
        red30 = (x >= lrmp_pkg::PRIME) ? (x - lrmp_pkg::PRIME) : x;
    endfunction

    function automatic logic [29:0] init_value(input logic [1:0] row, input logic [1:0] col,
                                               input lrmp_pkg::cfg_t c);
        logic [3:0] rc;
        rc = {row, col};
        case (rc)
            4'b11_00: init_value = red30(c.third);
            4'b11_01: init_value = red30(c.second);
            4'b11_10: init_value = red30(c.first);
            4'b00_00: init_value = red30(c.coef_one);
            4'b01_00: init_value = red30(c.coef_two);
            4'b10_00: init_value = red30(c.coef_three);
            4'b00_01: init_value = 30'd1;
            4'b01_10: init_value = 30'd1;
            default:  init_value = 30'd0;
        endcase
    endfunction

    logic [IW-1:0]       n_reg, n_next;
    logic                large_reg, large_next;
    logic                zero_reg, zero_next;
    logic                mbank_reg, mbank_next;
    logic                vbank_reg, vbank_next;

    logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
    logic [DW-1:0]       rd_a_data, rd_b_data, wr_data;
    logic                wr_en;
    logic [1:0]          fin_col;
    lrmp_pkg::tag_t      new_tag;

    logic [PS-1:0]       stage_valid_reg;
    lrmp_pkg::tag_t      tag_reg [PS];

    logic [59:0]         prod_reg;
    logic [61:0]         t_reg;
    logic [31:0]         lo3_reg, lo4_reg;
    logic [31:0]         qp_reg;
    logic [31:0]         r_reg;
    logic [29:0]         red_reg;
    logic [29:0]         acc_reg, acc_next;
    logic [30:0]         sum;
    logic [60:0]         qp_full;

    logic                m_valid_reg;
    logic [DW-1:0]       m_term_value_reg;

    // Index register and bank selects.
    always_comb begin
        n_next     = n_reg;
        large_next = large_reg;
        zero_next  = zero_reg;
        mbank_next = mbank_reg;
        vbank_next = vbank_reg;
        if (cmd.load) begin
            large_next = (s_index > IW'(3));
            zero_next  = (s_index == '0);
            n_next     = (s_index > IW'(3)) ? (s_index - IW'(3)) : s_index;
            mbank_next = 1'b0;
            vbank_next = 1'b0;
        end else if (cmd.step) begin
            n_next     = n_reg >> 1;
            mbank_next = ~mbank_reg;
            vbank_next = vbank_reg ^ n_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= '0;
            large_reg <= 1'b0;
            zero_reg  <= 1'b0;
            mbank_reg <= 1'b0;
            vbank_reg <= 1'b0;
        end else begin
            n_reg     <= n_next;
            large_reg <= large_next;
            zero_reg  <= zero_next;
            mbank_reg <= mbank_next;
            vbank_reg <= vbank_next;
        end
    end

    // Operand addresses: vector in row three, matrix in rows zero to two.
    assign fin_col = large_reg ? 2'd0 : (lrmp_pkg::FIN_BASE - n_reg[1:0]);

    always_comb begin
        rd_a_addr      = {vbank_reg, lrmp_pkg::ROW_VEC, fin_col};
        rd_b_addr      = '0;
        new_tag.first  = (cmd.k == lrmp_pkg::FIRST_IDX);
        new_tag.last   = (cmd.k == lrmp_pkg::LAST_IDX);
        new_tag.dest   = '0;
        if (cmd.issue) begin
            if (cmd.vec_phase) begin
                rd_a_addr    = {vbank_reg, lrmp_pkg::ROW_VEC, cmd.k};
                rd_b_addr    = {mbank_reg, cmd.k, cmd.i};
                new_tag.dest = {~vbank_reg, lrmp_pkg::ROW_VEC, cmd.i};
            end else begin
                rd_a_addr    = {mbank_reg, cmd.i, cmd.k};
                rd_b_addr    = {mbank_reg, cmd.k, cmd.j};
                new_tag.dest = {~mbank_reg, cmd.i, cmd.j};
            end
        end
    end

    lrmp_ram #(
        .WIDTH (DW),
        .DEPTH (lrmp_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            stage_valid_reg <= {stage_valid_reg[PS-2:0], cmd.issue};
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg[0] <= new_tag;
        for (int s = 1; s < PS; s++) begin
            tag_reg[s] <= tag_reg[s-1];
        end
    end

    // Barrett reduction of the product; the remainder ends below three times the prime.
    assign qp_full = 61'(t_reg[61:31]) * 61'(lrmp_pkg::PRIME);

    always_ff @(posedge aclk) begin
        prod_reg <= {30'd0, rd_a_data} * {30'd0, rd_b_data};
        t_reg    <= 62'(prod_reg[59:29]) * 62'(lrmp_pkg::BARRETT_MU);
        lo3_reg  <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        lo4_reg  <= lo3_reg;
        r_reg    <= lo4_reg - qp_reg;
        if (r_reg >= lrmp_pkg::PRIME_X2) begin
            red_reg <= 30'(r_reg - lrmp_pkg::PRIME_X2);
        end else if (r_reg >= 32'(lrmp_pkg::PRIME)) begin
            red_reg <= 30'(r_reg - 32'(lrmp_pkg::PRIME));
        end else begin
            red_reg <= r_reg[29:0];
        end
    end

    // Accumulator of the three products of one dot product.
    always_comb begin
        sum      = (tag_reg[PS-1].first ? 31'd0 : {1'b0, acc_reg}) + {1'b0, red_reg};
        acc_next = (sum >= 31'(lrmp_pkg::PRIME)) ? 30'(sum - 31'(lrmp_pkg::PRIME))
                                                 : sum[29:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_valid_reg[PS-1]) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        if (cmd.init_wr) begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, cmd.init_row, cmd.init_col};
            wr_data = init_value(cmd.init_row, cmd.init_col, cfg);
        end else begin
            wr_en   = stage_valid_reg[PS-1] && tag_reg[PS-1].last;
            wr_addr = tag_reg[PS-1].dest;
            wr_data = acc_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.capture) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_term_value_reg <= zero_reg ? '0 : rd_a_data;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_term_value = m_term_value_reg;

    assign status.n_zero   = (n_reg == '0);
    assign status.n_bit0   = n_reg[0];
    assign status.n_large  = large_reg;
    assign status.out_full = m_valid_reg;

    `ASSERT_IMPLIES(a_step_drained, aclk, aresetn, cmd.step, stage_valid_reg == '0)
    `ASSERT_IMPLIES(a_load_drained, aclk, aresetn, cmd.load, stage_valid_reg == '0)
    `ASSERT_IMPLIES(a_capture_free, aclk, aresetn, cmd.capture, !m_valid_reg)
    `ASSERT_IMPLIES(a_result_reduced, aclk, aresetn, m_valid_reg,
                    m_term_value_reg < lrmp_pkg::PRIME)

endmodule

[rtl/lrmp_ctrl.sv]
// Controller: sequences table load, product issue, pipeline drain,
// index steps and result capture. Depends on lrmp_pkg.
module lrmp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lrmp_pkg::status_t status,
    output lrmp_pkg::cmd_t    cmd
);

    lrmp_pkg::state_t              state_reg, state_next;
    logic [lrmp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]                    i_reg, i_next;
    logic [1:0]                    j_reg, j_next;
    logic [1:0]                    k_reg, k_next;
    logic                          vec_reg, vec_next;
    logic                          issue_done;

    assign issue_done = !vec_reg && (i_reg == lrmp_pkg::LAST_IDX)
                        && (j_reg == lrmp_pkg::LAST_IDX) && (k_reg == lrmp_pkg::LAST_IDX);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrmp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lrmp_pkg::ST_INIT;
                end
            end
            lrmp_pkg::ST_INIT: begin
                if (cnt_reg == lrmp_pkg::INIT_LAST) begin
                    state_next = lrmp_pkg::ST_CHECK;
                end
            end
            lrmp_pkg::ST_CHECK: begin
                if (!status.n_large || status.n_zero) begin
                    state_next = lrmp_pkg::ST_READ;
                end else begin
                    state_next = lrmp_pkg::ST_ISSUE;
                end
            end
            lrmp_pkg::ST_ISSUE: begin
                if (issue_done) begin
                    state_next = lrmp_pkg::ST_DRAIN;
                end
            end
            lrmp_pkg::ST_DRAIN: begin
                if (cnt_reg == lrmp_pkg::DRAIN_LAST) begin
                    state_next = lrmp_pkg::ST_STEP;
                end
            end
            lrmp_pkg::ST_STEP:    state_next = lrmp_pkg::ST_CHECK;
            lrmp_pkg::ST_READ:    state_next = lrmp_pkg::ST_CAPTURE;
            lrmp_pkg::ST_CAPTURE: begin
                if (!status.out_full) begin
                    state_next = lrmp_pkg::ST_IDLE;
                end
            end
            default: state_next = lrmp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = '0;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        vec_next = vec_reg;
        case (state_reg)
            lrmp_pkg::ST_INIT, lrmp_pkg::ST_DRAIN: begin
                cnt_next = cnt_reg + 1'b1;
            end
            lrmp_pkg::ST_CHECK: begin
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                vec_next = status.n_bit0;
            end
            lrmp_pkg::ST_ISSUE: begin
                if (k_reg != lrmp_pkg::LAST_IDX) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    if (vec_reg) begin
                        if (i_reg == lrmp_pkg::LAST_IDX) begin
                            i_next   = '0;
                            vec_next = 1'b0;
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end else if (j_reg != lrmp_pkg::LAST_IDX) begin
                        j_next = j_reg + 1'b1;
                    end else begin
                        j_next = '0;
                        i_next = (i_reg == lrmp_pkg::LAST_IDX) ? 2'd0 : i_reg + 1'b1;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.init_row  = cnt_reg[3:2];
        cmd.init_col  = cnt_reg[1:0];
        cmd.vec_phase = vec_reg;
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
        s_ready       = 1'b0;
        case (state_reg)
            lrmp_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lrmp_pkg::ST_INIT:    cmd.init_wr = 1'b1;
            lrmp_pkg::ST_ISSUE:   cmd.issue   = 1'b1;
            lrmp_pkg::ST_STEP:    cmd.step    = 1'b1;
            lrmp_pkg::ST_CAPTURE: cmd.capture = !status.out_full;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrmp_pkg::ST_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            vec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            vec_reg   <= vec_next;
        end
    end

endmodule

[rtl/linear_recurrence_mod_prime_core.sv]
// Top level of the linear recurrence core: APB register file and the
// controller and datapath instances. Depends on lrmp_pkg, lrmp_ctrl, lrmp_datapath.
//
// Returns term n of f(n) = c1*f(n-1) + c2*f(n-2) + c3*f(n-3) modulo 1000000007,
// with f(1..3) and c1..c3 taken from the APB registers (values at or above the
// prime are reduced once before use). One index beat is processed at a time.
// Each beat loads the companion matrix and start vector into the operand RAM,
// then for every bit of n-3 up to its highest set bit issues the products of the
// vector step (only when the bit is set) and of the matrix squaring, one per cycle,
// into the pipelined modular multiplier, drains it and steps the index, and
// finally returns the result. The next index beat is accepted while a finished
// result still waits in the output register.
module linear_recurrence_mod_prime_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lrmp_pkg::INDEX_BITS-1:0]      s_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lrmp_pkg::DATA_W-1:0]          m_term_value,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrmp_pkg::APB_AW-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    lrmp_pkg::cfg_t     cfg_reg, cfg_next;
    lrmp_pkg::reg_idx_t reg_idx;
    lrmp_pkg::cmd_t     cmd;
    lrmp_pkg::status_t  status;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = lrmp_pkg::reg_idx_t'(paddr[4:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                lrmp_pkg::REG_COEF_ONE:   cfg_next.coef_one   = pwdata[29:0];
                lrmp_pkg::REG_COEF_TWO:   cfg_next.coef_two   = pwdata[29:0];
                lrmp_pkg::REG_COEF_THREE: cfg_next.coef_three = pwdata[29:0];
                lrmp_pkg::REG_FIRST:      cfg_next.first      = pwdata[29:0];
                lrmp_pkg::REG_SECOND:     cfg_next.second     = pwdata[29:0];
                lrmp_pkg::REG_THIRD:      cfg_next.third      = pwdata[29:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lrmp_pkg::REG_COEF_ONE:   prdata = {2'b00, cfg_reg.coef_one};
            lrmp_pkg::REG_COEF_TWO:   prdata = {2'b00, cfg_reg.coef_two};
            lrmp_pkg::REG_COEF_THREE: prdata = {2'b00, cfg_reg.coef_three};
            lrmp_pkg::REG_FIRST:      prdata = {2'b00, cfg_reg.first};
            lrmp_pkg::REG_SECOND:     prdata = {2'b00, cfg_reg.second};
            lrmp_pkg::REG_THIRD:      prdata = {2'b00, cfg_reg.third};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_one   <= lrmp_pkg::RST_COEF_ONE;
            cfg_reg.coef_two   <= lrmp_pkg::RST_COEF_TWO;
            cfg_reg.coef_three <= lrmp_pkg::RST_COEF_THREE;
            cfg_reg.first      <= lrmp_pkg::RST_FIRST;
            cfg_reg.second     <= lrmp_pkg::RST_SECOND;
            cfg_reg.third      <= lrmp_pkg::RST_THIRD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lrmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lrmp_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg_reg),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_term_value (m_term_value)
    );

endmodule
